// ===== design/usv_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_pkg
// Shared types, constants and tables of the uv sphere vertex generator.
// ---------------------------------------------------------------------------
package usv_pkg;

   // divider: one quotient bit per step, numerator index * 2^25
   localparam int DIV_STEPS  = 26;
   localparam int DIV_PER    = 4;
   localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;
   localparam int QUOT_W     = DIV_STEPS;

   // cordic: prep stage, rotation stages, quadrant map stage
   localparam int CORD_STEPS  = 18;
   localparam int CORD_PER    = 3;
   localparam int CORD_STAGES = CORD_STEPS / CORD_PER + 2;
   localparam int CW          = 33;
   localparam int ZW          = 25;
   localparam logic signed [CW-1:0] CORD_GAIN = 33'sd652032874;
   localparam logic signed [CW-1:0] ONE_Q30   = 33'sd1073741824;

   localparam int OUT_STAGES = 4;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 192;
   localparam int RSP_USER_W = 2;

   typedef enum logic [1:0] {
      CSR_RADIUS   = 2'd0,
      CSR_RINGS    = 2'd1,
      CSR_SEGMENTS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] ring;
      logic [7:0] seg;
      logic       vvalid;
      logic       qvalid;
   } meta_type;

   typedef struct packed {
      meta_type          meta;
      logic [8:0]        rem_i;
      logic [8:0]        rem_j;
      logic [QUOT_W-1:0] quot_i;
      logic [QUOT_W-1:0] quot_j;
   } div_type;

   typedef struct packed {
      meta_type              meta;
      logic [15:0]           tex_u;
      logic [15:0]           tex_v;
      logic [1:0]            quad_p;
      logic [1:0]            quad_t;
      logic                  zero_p;
      logic                  zero_t;
      logic signed [CW-1:0]  x_p;
      logic signed [CW-1:0]  y_p;
      logic signed [ZW-1:0]  z_p;
      logic signed [CW-1:0]  x_t;
      logic signed [CW-1:0]  y_t;
      logic signed [ZW-1:0]  z_t;
   } cord_type;

   typedef struct packed {
      logic signed [24:0] pos_x;
      logic signed [24:0] pos_y;
      logic signed [24:0] pos_z;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic [15:0]        corner_low;
      logic [15:0]        corner_high;
      logic               quad_valid;
      logic               vertex_valid;
   } rsp_type;

   // arctangent of 2^-k in units of 2^-24 turn
   function automatic logic [21:0] cord_atan(input int unsigned k);
      case (k)
         0:       cord_atan = 22'd2097152;
         1:       cord_atan = 22'd1238021;
         2:       cord_atan = 22'd654137;
         3:       cord_atan = 22'd332051;
         4:       cord_atan = 22'd166668;
         5:       cord_atan = 22'd83415;
         6:       cord_atan = 22'd41718;
         7:       cord_atan = 22'd20860;
         8:       cord_atan = 22'd10430;
         9:       cord_atan = 22'd5215;
         10:      cord_atan = 22'd2608;
         11:      cord_atan = 22'd1304;
         12:      cord_atan = 22'd652;
         13:      cord_atan = 22'd326;
         14:      cord_atan = 22'd163;
         15:      cord_atan = 22'd81;
         16:      cord_atan = 22'd41;
         17:      cord_atan = 22'd20;
         default: cord_atan = 22'd0;
      endcase
   endfunction

endpackage

// ===== design/usv_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_div
// Pipelined restoring dividers: index * 2^25 / count for ring and segment.
// ---------------------------------------------------------------------------
module usv_div
   import usv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  meta_type   in_meta,
   input  logic [7:0] ring_count,
   input  logic [7:0] segment_count,
   output logic       out_valid,
   input  logic       out_ready,
   output div_type    out_data
);

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES:0]   rdy;
   div_type               stage_ff [DIV_STAGES];
   div_type               stage_in [DIV_STAGES];

   function automatic logic [9:0] div_step(input logic [8:0] rem, input logic [7:0] dv,
                                           input logic first);
      logic [8:0] r;
      logic       q;
      r = first ? rem : {rem[7:0], 1'b0};
      q = 1'b0;
      if (r >= {1'b0, dv}) begin
         r = r - {1'b0, dv};
         q = 1'b1;
      end
      div_step = {q, r};
   endfunction

   function automatic div_type div_advance(input div_type d, input int unsigned k,
                                           input logic [7:0] rc, input logic [7:0] sc);
      div_type     o;
      logic [9:0]  si;
      logic [9:0]  sj;
      int unsigned g;
      o = d;
      for (int unsigned s = 0; s < DIV_PER; s++) begin
         g = k * DIV_PER + s;
         if (g < DIV_STEPS) begin
            si = div_step(o.rem_i, rc, g == 0);
            sj = div_step(o.rem_j, sc, g == 0);
            o.rem_i  = si[8:0];
            o.rem_j  = sj[8:0];
            o.quot_i = {o.quot_i[QUOT_W-2:0], si[9]};
            o.quot_j = {o.quot_j[QUOT_W-2:0], sj[9]};
         end
      end
      div_advance = o;
   endfunction

   always_comb begin
      div_type init;
      init.meta   = in_meta;
      init.rem_i  = {1'b0, in_meta.ring};
      init.rem_j  = {1'b0, in_meta.seg};
      init.quot_i = '0;
      init.quot_j = '0;
      stage_in[0] = div_advance(init, 0, ring_count, segment_count);
      for (int k = 1; k < DIV_STAGES; k++) begin
         stage_in[k] = div_advance(stage_ff[k-1], k, ring_count, segment_count);
      end
   end

   always_comb begin
      rdy[DIV_STAGES] = out_ready;
      for (int k = DIV_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STAGES; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (rdy[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = stage_ff[DIV_STAGES-1];

endmodule

// ===== design/usv_cordic.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_cordic
// Angle and texture prep, then pipelined sine/cosine of latitude and longitude.
// ---------------------------------------------------------------------------
module usv_cordic
   import usv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  div_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output cord_type out_data
);

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } rot_type;

   logic [CORD_STAGES-1:0] valid_ff;
   logic [CORD_STAGES:0]   rdy;
   cord_type               stage_ff [CORD_STAGES];
   cord_type               stage_in [CORD_STAGES];

   function automatic rot_type rot_step(input rot_type r, input int unsigned g);
      rot_type              o;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] at;
      dx = r.x >>> g;
      dy = r.y >>> g;
      at = $signed({3'b000, cord_atan(g)});
      o  = r;
      if (!r.z[ZW-1]) begin
         o.x = r.x - dy;
         o.y = r.y + dx;
         o.z = r.z - at;
      end else begin
         o.x = r.x + dy;
         o.y = r.y - dx;
         o.z = r.z + at;
      end
      rot_step = o;
   endfunction

   function automatic logic signed [CW-1:0] clamp30(input logic signed [CW-1:0] v);
      if (v > ONE_Q30) clamp30 = ONE_Q30;
      else if (v < -ONE_Q30) clamp30 = -ONE_Q30;
      else clamp30 = v;
   endfunction

   // returns {cos, sin}
   function automatic logic [2*CW-1:0] quad_map(input logic signed [CW-1:0] x,
                                                input logic signed [CW-1:0] y,
                                                input logic zero, input logic [1:0] quad);
      logic signed [CW-1:0] cr;
      logic signed [CW-1:0] sr;
      if (zero) begin
         cr = ONE_Q30;
         sr = '0;
      end else begin
         cr = clamp30(x);
         sr = clamp30(y);
      end
      case (quad)
         QUAD_I:   quad_map = {cr, sr};
         QUAD_II:  quad_map = {-sr, cr};
         QUAD_III: quad_map = {-cr, -sr};
         default:  quad_map = {sr, -cr};
      endcase
   endfunction

   function automatic cord_type cord_prep(input div_type d);
      cord_type          o;
      logic [QUOT_W-1:0] phi_sum;
      logic [QUOT_W-1:0] theta_sum;
      logic [QUOT_W-1:0] u_sum;
      logic [QUOT_W-1:0] v_sum;
      logic [23:0]       phi;
      logic [23:0]       theta;
      // rounding of the 2^25 scaled quotients to angle and texture grids
      phi_sum   = d.quot_i + QUOT_W'(2);
      theta_sum = d.quot_j + QUOT_W'(1);
      v_sum     = d.quot_i + QUOT_W'(512);
      u_sum     = d.quot_j + QUOT_W'(512);
      phi       = phi_sum[QUOT_W-1:2];
      theta     = theta_sum[QUOT_W-2:1];
      o.meta    = d.meta;
      o.tex_u   = 16'd32768 - u_sum[QUOT_W-1:10];
      o.tex_v   = 16'd32768 - v_sum[QUOT_W-1:10];
      o.quad_p  = phi[23:22];
      o.quad_t  = theta[23:22];
      o.zero_p  = (phi[21:0] == 22'd0);
      o.zero_t  = (theta[21:0] == 22'd0);
      o.x_p     = CORD_GAIN;
      o.y_p     = '0;
      o.z_p     = $signed({3'b000, phi[21:0]});
      o.x_t     = CORD_GAIN;
      o.y_t     = '0;
      o.z_t     = $signed({3'b000, theta[21:0]});
      cord_prep = o;
   endfunction

   function automatic cord_type cord_rotate(input cord_type c, input int unsigned k);
      cord_type    o;
      rot_type     rp;
      rot_type     rt;
      int unsigned g;
      o  = c;
      rp = '{x: c.x_p, y: c.y_p, z: c.z_p};
      rt = '{x: c.x_t, y: c.y_t, z: c.z_t};
      for (int unsigned s = 0; s < CORD_PER; s++) begin
         g  = (k - 1) * CORD_PER + s;
         rp = rot_step(rp, g);
         rt = rot_step(rt, g);
      end
      o.x_p = rp.x;
      o.y_p = rp.y;
      o.z_p = rp.z;
      o.x_t = rt.x;
      o.y_t = rt.y;
      o.z_t = rt.z;
      cord_rotate = o;
   endfunction

   always_comb begin
      cord_type m;
      stage_in[0] = cord_prep(in_data);
      for (int k = 1; k < CORD_STAGES - 1; k++) begin
         stage_in[k] = cord_rotate(stage_ff[k-1], k);
      end
      // x holds cosine and y holds sine from here on
      m = stage_ff[CORD_STAGES-2];
      {m.x_p, m.y_p} = quad_map(m.x_p, m.y_p, m.zero_p, m.quad_p);
      {m.x_t, m.y_t} = quad_map(m.x_t, m.y_t, m.zero_t, m.quad_t);
      stage_in[CORD_STAGES-1] = m;
   end

   always_comb begin
      rdy[CORD_STAGES] = out_ready;
      for (int k = CORD_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < CORD_STAGES; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CORD_STAGES; k++) begin
         if (rdy[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[CORD_STAGES-1];
   assign out_data  = stage_ff[CORD_STAGES-1];

endmodule

// ===== design/usv_shade.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_shade
// Direction products, radius scaling, normals, quad corners and the result.
// ---------------------------------------------------------------------------
module usv_shade
   import usv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  cord_type    in_data,
   input  logic [23:0] sphere_radius,
   input  logic [7:0]  segment_count,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_data
);

   typedef struct packed {
      meta_type           meta;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic signed [63:0] p0;
      logic signed [63:0] p2;
      logic signed [31:0] d0;
      logic signed [31:0] d1;
      logic signed [31:0] d2;
      logic signed [56:0] q0;
      logic signed [56:0] q1;
      logic signed [56:0] q2;
      logic signed [15:0] n0;
      logic signed [15:0] n1;
      logic signed [15:0] n2;
      rsp_type            rsp;
   } sh_type;

   logic [OUT_STAGES-1:0] valid_ff;
   logic [OUT_STAGES:0]   rdy;
   sh_type                stage_ff [OUT_STAGES];
   sh_type                stage_in [OUT_STAGES];

   function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd536870912) >>> 30;
      rnd30 = t[31:0];
   endfunction

   function automatic logic signed [15:0] norm15(input logic signed [31:0] d);
      logic signed [31:0] t;
      t = (d + 32'sd16384) >>> 15;
      if (t > 32'sd32767) norm15 = 16'sd32767;
      else if (t < -32'sd32767) norm15 = -16'sd32767;
      else norm15 = t[15:0];
   endfunction

   function automatic logic signed [24:0] pos30(input logic signed [56:0] q);
      logic signed [56:0] t;
      t = (q + 57'sd536870912) >>> 30;
      if (t > 57'sd16777215) pos30 = 25'sd16777215;
      else if (t < -57'sd16777215) pos30 = -25'sd16777215;
      else pos30 = t[24:0];
   endfunction

   always_comb begin
      sh_type             s0;
      sh_type             s1;
      sh_type             s2;
      sh_type             s3;
      logic signed [31:0] sp;
      logic signed [31:0] ct;
      logic signed [31:0] st;
      logic signed [31:0] da;
      logic signed [31:0] db;
      logic signed [31:0] dc;
      logic signed [24:0] rs;
      logic [16:0]        prod;
      logic [15:0]        ca;
      logic               live;

      // products of latitude sine with longitude cosine and sine
      s0       = '0;
      s0.meta  = in_data.meta;
      s0.tex_u = in_data.tex_u;
      s0.tex_v = in_data.tex_v;
      sp       = in_data.y_p[31:0];
      ct       = in_data.x_t[31:0];
      st       = in_data.y_t[31:0];
      s0.p0    = sp * ct;
      s0.p2    = sp * st;
      s0.d1    = in_data.x_p[31:0];
      stage_in[0] = s0;

      s1    = stage_ff[0];
      s1.d0 = rnd30(stage_ff[0].p0);
      s1.d2 = rnd30(stage_ff[0].p2);
      stage_in[1] = s1;

      s2    = stage_ff[1];
      rs    = $signed({1'b0, sphere_radius});
      da    = stage_ff[1].d0;
      db    = stage_ff[1].d1;
      dc    = stage_ff[1].d2;
      s2.q0 = rs * da;
      s2.q1 = rs * db;
      s2.q2 = rs * dc;
      s2.n0 = norm15(da);
      s2.n1 = norm15(db);
      s2.n2 = norm15(dc);
      stage_in[2] = s2;

      s3     = stage_ff[2];
      s3.rsp = '0;
      live   = stage_ff[2].meta.vvalid && (sphere_radius != 24'd0);
      if (live) begin
         s3.rsp.pos_x    = pos30(stage_ff[2].q0);
         s3.rsp.pos_y    = pos30(stage_ff[2].q1);
         s3.rsp.pos_z    = pos30(stage_ff[2].q2);
         s3.rsp.normal_x = stage_ff[2].n0;
         s3.rsp.normal_y = stage_ff[2].n1;
         s3.rsp.normal_z = stage_ff[2].n2;
      end
      if (stage_ff[2].meta.vvalid) begin
         s3.rsp.tex_u        = stage_ff[2].tex_u;
         s3.rsp.tex_v        = stage_ff[2].tex_v;
         s3.rsp.vertex_valid = 1'b1;
      end
      prod = stage_ff[2].meta.ring * ({1'b0, segment_count} + 9'd1);
      ca   = prod[15:0] + {8'd0, stage_ff[2].meta.seg};
      if (stage_ff[2].meta.qvalid) begin
         s3.rsp.corner_low  = ca;
         s3.rsp.corner_high = ca + {8'd0, segment_count} + 16'd1;
         s3.rsp.quad_valid  = 1'b1;
      end
      stage_in[3] = s3;
   end

   always_comb begin
      rdy[OUT_STAGES] = out_ready;
      for (int k = OUT_STAGES - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (rdy[0]) valid_ff[0] <= in_valid;
         for (int k = 1; k < OUT_STAGES; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < OUT_STAGES; k++) begin
         if (rdy[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[OUT_STAGES-1];
   assign out_data  = stage_ff[OUT_STAGES-1].rsp;

endmodule

// ===== design/uv_sphere_vertex_generator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uv_sphere_vertex_generator
// One uv sphere vertex, texture coordinate, normal and quad corners per item.
// ---------------------------------------------------------------------------
// Accepts one item per cycle while the output is not stalled; each item passes
// 7 divider stages, 8 cordic stages and 4 scaling stages. Every stage has its
// own valid bit, so bubbles close up and a stalled output does not block
// accepting while earlier stages are empty. Two pipelined 26-bit restoring
// dividers turn indices into angles. The user writes configuration registers
// only while no item is in flight; the block itself does not enforce it.
module uv_sphere_vertex_generator
   import usv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ring_index [7:0], segment_index [15:8]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, normal_x, normal_y, normal_z,
   // corner_low, corner_high, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // quad_valid, vertex_valid
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wen,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wdata
);

   logic [23:0] radius_ff;
   logic [7:0]  rings_ff;
   logic [7:0]  segs_ff;
   meta_type    req_meta;
   logic        div_valid;
   logic        div_ready;
   div_type     div_data;
   logic        cord_valid;
   logic        cord_ready;
   cord_type    cord_data;
   rsp_type     rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 24'd25600;
         rings_ff  <= 8'd16;
         segs_ff   <= 8'd32;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_RADIUS:   radius_ff <= csr_wdata;
            CSR_RINGS:    rings_ff  <= csr_wdata[7:0];
            CSR_SEGMENTS: segs_ff   <= csr_wdata[7:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      req_meta.ring   = req_tdata[7:0];
      req_meta.seg    = req_tdata[15:8];
      req_meta.vvalid = (rings_ff != 8'd0) && (segs_ff >= 8'd3) &&
                        (req_tdata[7:0] <= rings_ff) && (req_tdata[15:8] <= segs_ff);
      req_meta.qvalid = req_meta.vvalid && (req_tdata[7:0] < rings_ff) &&
                        (req_tdata[15:8] < segs_ff);
   end

   usv_div u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_meta       (req_meta),
      .ring_count    (rings_ff),
      .segment_count (segs_ff),
      .out_valid     (div_valid),
      .out_ready     (div_ready),
      .out_data      (div_data)
   );

   usv_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (cord_valid),
      .out_ready (cord_ready),
      .out_data  (cord_data)
   );

   usv_shade u_shade (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cord_valid),
      .in_ready      (cord_ready),
      .in_data       (cord_data),
      .sphere_radius (radius_ff),
      .segment_count (segs_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_data      (rsp)
   );

   assign rsp_tdata = {5'd0, rsp.corner_high, rsp.corner_low, rsp.normal_z, rsp.normal_y,
                       rsp.normal_x, rsp.tex_v, rsp.tex_u, rsp.pos_z, rsp.pos_y, rsp.pos_x};
   assign rsp_tuser = {rsp.vertex_valid, rsp.quad_valid};

endmodule

// ===== design/usv_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// usv_checker
// Port level checks of the vertex generator result stream.
// ---------------------------------------------------------------------------
module usv_checker
   import usv_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> (rsp_tdata == '0) && !rsp_tuser[0])
      else $error("invalid vertex carries data");

   a_no_quad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[186:155] == 32'd0))
      else $error("corners set without quad");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[186:171] > rsp_tdata[170:155]))
      else $error("upper corner not above lower corner");

endmodule

bind uv_sphere_vertex_generator usv_checker u_usv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the uv sphere vertex generator.
// ---------------------------------------------------------------------------
// Drives ring/segment index items through the stream input. A bit-exact
// fixed-point sphere predictor, or a fixed row value for typed directed rows,
// gives each expected vertex; the bench checks every returned item against it.
// The configuration is changed between phases: zero and full radius,
// degenerate and maximal ring and segment counts, and writes to the unused
// register index. The sender runs in bursts, and the receiver stalls on its own
// pattern and sometimes holds off for a long stretch.
module tb;
   import usv_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam longint ONE30 = 64'sd1 << 30;
   localparam longint GAIN = 64'sd652032874;
   localparam longint POS_LIM = 16777215;
   localparam longint NRM_LIM = 32767;
   localparam longint TURN_ATAN [18] = '{2097152, 1238021, 654137, 332051, 166668,
      83415, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_wen = 1'b0;
   logic [1:0]            csr_index = CSR_RADIUS;
   logic [23:0]           csr_wdata = '0;

   uv_sphere_vertex_generator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20ms;
      $display("uv_sphere_vertex_generator: mismatch");
      $finish;
   end

   // predictor copy of the registers
   longint unsigned radius_q = 25600;
   longint unsigned rings_q  = 16;
   longint unsigned segs_q   = 32;

   rsp_type vertex_q[$];
   int errors = 0;
   int items_sent = 0;
   int vertices_seen = 0;
   int valid_seen = 0;
   int quads_seen = 0;
   int burst_left = 0;

   function automatic longint rnd_shift(longint v, int k);
      return (v + (64'sd1 << (k - 1))) >>> k;
   endfunction

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // quadrant fold plus cordic rotation, angle in 2^-24 turn
   task automatic turn_sin_cos(input longint unsigned ang, output longint s,
                               output longint c);
      logic [1:0] quad;
      longint z, x, y, cr, sr, dx, dy;
      quad = ang[23:22];
      z = longint'(ang & 64'h3FFFFF);
      x = GAIN;
      y = 0;
      if (z == 0) begin
         cr = ONE30;
         sr = 0;
      end else begin
         for (int k = 0; k < 18; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= TURN_ATAN[k];
            end else begin
               x += dx; y -= dy; z += TURN_ATAN[k];
            end
         end
         cr = clip(x, ONE30);
         sr = clip(y, ONE30);
      end
      case (quad)
         2'd0: begin c = cr;  s = sr;  end
         2'd1: begin c = -sr; s = cr;  end
         2'd2: begin c = -cr; s = -sr; end
         default: begin c = sr; s = -cr; end
      endcase
   endtask

   task automatic sphere_vertex(input longint unsigned i, input longint unsigned j,
                                output rsp_type v);
      longint unsigned phi, theta, a;
      longint sp, cp, st, ct, r;
      longint dir [3];
      longint pos [3];
      longint nrm [3];
      v = '0;
      if (!(rings_q >= 1 && segs_q >= 3 && rings_q <= 255 && segs_q <= 255 &&
            i <= rings_q && j <= segs_q))
         return;
      r = longint'(radius_q);
      phi = (((i << 24) + rings_q) / (2 * rings_q)) & 64'hFFFFFF;
      theta = (((j << 25) + segs_q) / (2 * segs_q)) & 64'hFFFFFF;
      turn_sin_cos(phi, sp, cp);
      turn_sin_cos(theta, st, ct);
      dir[0] = rnd_shift(sp * ct, 30);
      dir[1] = cp;
      dir[2] = rnd_shift(sp * st, 30);
      for (int n = 0; n < 3; n++) begin
         if (r == 0) begin
            pos[n] = 0;
            nrm[n] = 0;
         end else begin
            pos[n] = clip(rnd_shift(r * dir[n], 30), POS_LIM);
            nrm[n] = clip(rnd_shift(dir[n], 15), NRM_LIM);
         end
      end
      v.pos_x = pos[0][24:0];
      v.pos_y = pos[1][24:0];
      v.pos_z = pos[2][24:0];
      v.normal_x = nrm[0][15:0];
      v.normal_y = nrm[1][15:0];
      v.normal_z = nrm[2][15:0];
      v.tex_u = 16'(32768 - ((j << 16) + segs_q) / (2 * segs_q));
      v.tex_v = 16'(32768 - ((i << 16) + rings_q) / (2 * rings_q));
      if (i < rings_q && j < segs_q) begin
         a = (i * (segs_q + 1) + j) & 64'hFFFF;
         v.corner_low = a[15:0];
         v.corner_high = 16'(a + segs_q + 1);
         v.quad_valid = 1'b1;
      end
      v.vertex_valid = 1'b1;
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [23:0] val);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_RADIUS:   radius_q = val;
         CSR_RINGS:    rings_q = val[7:0];
         CSR_SEGMENTS: segs_q = val[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // offer one item; returns on the edge that accepted it
   task automatic offer_item(input logic [7:0] i, input logic [7:0] j, input bit typed,
                             input rsp_type known);
      rsp_type v;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {j, i};
      do @(posedge clock); while (!req_tready);
      if (typed) v = known;
      else sphere_vertex(i, j, v);
      vertex_q.push_back(v);
      items_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      wait (vertex_q.size() == 0);
      repeat (25) @(posedge clock);
   endtask

   task automatic random_items(input int n);
      logic [7:0] i, j;
      rsp_type none;
      none = '0;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < 85 && rings_q >= 1 && segs_q >= 1) begin
            i = 8'($urandom_range(0, int'(rings_q)));
            j = 8'($urandom_range(0, int'(segs_q)));
         end else begin
            i = 8'($urandom_range(0, 255));
            j = 8'($urandom_range(0, 255));
         end
         offer_item(i, j, 1'b0, none);
      end
   endtask

   // directed rows at the reset configuration
   typedef struct {
      logic [7:0] ring;
      logic [7:0] seg;
      bit         typed;
      rsp_type    vertex;
   } row_type;

   row_type rows [$];
   rsp_type north_pole, nothing;

   initial begin
      north_pole = '0;
      north_pole.pos_y = 25'sd25600;
      north_pole.normal_y = 16'sd32767;
      north_pole.tex_u = 16'd32768;
      north_pole.tex_v = 16'd32768;
      north_pole.corner_high = 16'd33;
      north_pole.quad_valid = 1'b1;
      north_pole.vertex_valid = 1'b1;
      nothing = '0;
      rows = '{
         '{8'd0,   8'd0,   1'b1, north_pole},
         '{8'd17,  8'd0,   1'b1, nothing},
         '{8'd0,   8'd33,  1'b1, nothing},
         '{8'd255, 8'd255, 1'b1, nothing},
         '{8'd255, 8'd0,   1'b1, nothing},
         '{8'd0,   8'd255, 1'b1, nothing},
         '{8'd16,  8'd32,  1'b0, nothing},
         '{8'd16,  8'd0,   1'b0, nothing},
         '{8'd0,   8'd32,  1'b0, nothing},
         '{8'd8,   8'd0,   1'b0, nothing},
         '{8'd8,   8'd8,   1'b0, nothing},
         '{8'd8,   8'd16,  1'b0, nothing},
         '{8'd8,   8'd24,  1'b0, nothing},
         '{8'd15,  8'd31,  1'b0, nothing},
         '{8'd4,   8'd5,   1'b0, nothing},
         '{8'd12,  8'd27,  1'b0, nothing},
         '{8'd1,   8'd1,   1'b0, nothing},
         '{8'd16,  8'd31,  1'b0, nothing},
         '{8'd15,  8'd32,  1'b0, nothing},
         '{8'd170, 8'd85,  1'b1, nothing}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[k]) offer_item(rows[k].ring, rows[k].seg, rows[k].typed, rows[k].vertex);
      random_items(100);
      drain();

      // unused index must leave every register alone
      csr_write(CSR_UNUSED, 24'hFFFFFF);
      random_items(60);
      drain();

      csr_write(CSR_RADIUS, 24'd0);
      random_items(100);
      drain();

      csr_write(CSR_RADIUS, 24'hFFFFFF);
      csr_write(CSR_RINGS, 24'd255);
      csr_write(CSR_SEGMENTS, 24'd255);
      random_items(150);
      drain();

      csr_write(CSR_RADIUS, 24'd1);
      csr_write(CSR_RINGS, 24'd1);
      csr_write(CSR_SEGMENTS, 24'd3);
      random_items(100);
      drain();

      csr_write(CSR_RINGS, 24'd0);
      random_items(60);
      drain();

      csr_write(CSR_RINGS, 24'hABCD07);
      csr_write(CSR_SEGMENTS, 24'd2);
      random_items(60);
      drain();

      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_RADIUS, 24'($urandom()));
         csr_write(CSR_RINGS, 24'($urandom_range(1, 255)));
         csr_write(CSR_SEGMENTS, 24'($urandom_range(3, 255)));
         random_items(115);
         drain();
      end

      $display("%0d items sent, %0d vertices returned (%0d valid, %0d with a quad)",
               items_sent, vertices_seen, valid_seen, quads_seen);
      $display("covered zero and full radius, degenerate and maximal ring/segment counts");
      if (errors == 0) begin
         $display("uv_sphere_vertex_generator: match");
      end else begin
         $display("uv_sphere_vertex_generator: mismatch");
      end
      $finish;
   end

   // receiver: random stalls with stall-free stretches and a rare long hold-off
   initial begin
      int cycle, hold, mode_left;
      bit choppy;
      cycle = 0;
      hold = 0;
      mode_left = 0;
      choppy = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle % 3000 == 300) hold = 250;
         if (mode_left == 0) begin
            choppy = $urandom_range(0, 1);
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input longint want, input longint got,
                              inout bit bad);
      if (want != got) begin
         if (errors < 10)
            $display("vertex %0d: %s expected %0h got %0h", vertices_seen, name, want, got);
         bad = 1'b1;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      rsp_type got, want;
      bit bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pos_x = rsp_tdata[24:0];
         got.pos_y = rsp_tdata[49:25];
         got.pos_z = rsp_tdata[74:50];
         got.tex_u = rsp_tdata[90:75];
         got.tex_v = rsp_tdata[106:91];
         got.normal_x = rsp_tdata[122:107];
         got.normal_y = rsp_tdata[138:123];
         got.normal_z = rsp_tdata[154:139];
         got.corner_low = rsp_tdata[170:155];
         got.corner_high = rsp_tdata[186:171];
         got.quad_valid = rsp_tuser[0];
         got.vertex_valid = rsp_tuser[1];
         bad = 1'b0;
         if (vertex_q.size() == 0) begin
            if (errors < 10) $display("unexpected vertex %0d", vertices_seen);
            errors++;
         end else begin
            want = vertex_q.pop_front();
            check_field("pos_x", want.pos_x, got.pos_x, bad);
            check_field("pos_y", want.pos_y, got.pos_y, bad);
            check_field("pos_z", want.pos_z, got.pos_z, bad);
            check_field("tex_u", want.tex_u, got.tex_u, bad);
            check_field("tex_v", want.tex_v, got.tex_v, bad);
            check_field("normal_x", want.normal_x, got.normal_x, bad);
            check_field("normal_y", want.normal_y, got.normal_y, bad);
            check_field("normal_z", want.normal_z, got.normal_z, bad);
            check_field("corner_low", want.corner_low, got.corner_low, bad);
            check_field("corner_high", want.corner_high, got.corner_high, bad);
            check_field("quad_valid", want.quad_valid, got.quad_valid, bad);
            check_field("vertex_valid", want.vertex_valid, got.vertex_valid, bad);
            if (bad) errors++;
         end
         vertices_seen++;
         if (got.vertex_valid) valid_seen++;
         if (got.quad_valid) quads_seen++;
      end
   end

endmodule
